FILE: src/fixed_point_q24_8_alu_defines.svh
// assertion macros shared by the q24.8 alu checker
// no dependencies; include guarded
`ifndef FIXED_POINT_Q24_8_ALU_DEFINES_SVH
`define FIXED_POINT_Q24_8_ALU_DEFINES_SVH

// same-cycle implication, disabled during reset
`define FPA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define FPA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/fpa_pkg.sv
// types, opcodes and saturation helpers for the q24.8 fixed-point alu
// no dependencies
package fpa_pkg;

    localparam int WORD_W        = 32;
    localparam int FRAC_BITS_DEF = 8;

    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_GT       = 4'd4,
        OP_LT       = 4'd5,
        OP_GE       = 4'd6,
        OP_LE       = 4'd7,
        OP_EQ       = 4'd8,
        OP_NE       = 4'd9,
        OP_INC      = 4'd10,
        OP_DEC      = 4'd11,
        OP_MIN      = 4'd12,
        OP_MAX      = 4'd13,
        OP_TO_INT   = 4'd14,
        OP_FROM_INT = 4'd15
    } fpa_op_t;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_DIVZ = 2'd2;

    localparam logic [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    typedef struct packed {
        logic [3:0]        req_type;
        logic [WORD_W-1:0] operand_a;
        logic [WORD_W-1:0] operand_b;
    } fpa_req_t;

    typedef struct packed {
        logic [WORD_W-1:0] result_value;
        logic              compare_true;
        logic [1:0]        status;
    } fpa_rsp_t;

    // fields riding alongside the divider
    typedef struct packed {
        fpa_op_t             op;
        logic                neg;
        logic [WORD_W-1:0]   res;
        logic                cmp;
        logic [1:0]          st;
        logic [2*WORD_W-1:0] prod;
    } fpa_side_t;

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic              ovf;
    } fpa_sat_t;

    // clamp a one-bit-wider signed sum to the word range
    function automatic fpa_sat_t fpa_sat_sum(logic [WORD_W:0] v);
        fpa_sat_t s;
        s.ovf   = v[WORD_W] ^ v[WORD_W-1];
        s.value = s.ovf ? (v[WORD_W] ? WORD_MIN : WORD_MAX) : v[WORD_W-1:0];
        return s;
    endfunction

    // apply sign to a rounded magnitude and saturate
    function automatic fpa_sat_t fpa_sat_mag(logic [2*WORD_W:0] m, logic neg);
        fpa_sat_t          s;
        logic [2*WORD_W:0] lim;
        lim = {{(WORD_W+1){1'b0}}, WORD_MIN};
        if (neg) begin
            s.ovf   = m > lim;
            s.value = s.ovf ? WORD_MIN : (~m[WORD_W-1:0] + 1'b1);
        end
        else begin
            s.ovf   = m > (lim - 1'b1);
            s.value = s.ovf ? WORD_MAX : m[WORD_W-1:0];
        end
        return s;
    endfunction

endpackage

FILE: src/fpa_div_stage.sv
// one registered restoring-division step with side fields carried along
// depends on fpa_pkg
module fpa_div_stage #(
    parameter int NUM_W = fpa_pkg::WORD_W + fpa_pkg::FRAC_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  fpa_pkg::fpa_side_t        in_side,
    input  logic [NUM_W-1:0]          in_num,
    input  logic [fpa_pkg::WORD_W-1:0] in_rem,
    input  logic [fpa_pkg::WORD_W-1:0] in_den,
    output logic                      out_valid,
    output fpa_pkg::fpa_side_t        out_side,
    output logic [NUM_W-1:0]          out_num,
    output logic [fpa_pkg::WORD_W-1:0] out_rem,
    output logic [fpa_pkg::WORD_W-1:0] out_den
);

    logic                        valid_reg;
    fpa_pkg::fpa_side_t          side_reg;
    logic [NUM_W-1:0]            num_reg, num_next;
    logic [fpa_pkg::WORD_W-1:0]  rem_reg, rem_next;
    logic [fpa_pkg::WORD_W-1:0]  den_reg;
    logic [fpa_pkg::WORD_W:0]    shifted;
    logic [fpa_pkg::WORD_W:0]    diff;
    logic                        ge;

    always_comb
    begin
        shifted  = {in_rem, in_num[NUM_W-1]};
        ge       = shifted >= {1'b0, in_den};
        diff     = shifted - {1'b0, in_den};
        rem_next = ge ? diff[fpa_pkg::WORD_W-1:0] : shifted[fpa_pkg::WORD_W-1:0];
        num_next = {in_num[NUM_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= in_side;
            num_reg  <= num_next;
            rem_reg  <= rem_next;
            den_reg  <= in_den;
        end
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_num   = num_reg;
    assign out_rem   = rem_reg;
    assign out_den   = den_reg;

endmodule

FILE: src/fpa_divider.sv
// pipelined restoring divider, one quotient bit per stage
// depends on fpa_pkg and fpa_div_stage
module fpa_divider #(
    parameter int NUM_W = fpa_pkg::WORD_W + fpa_pkg::FRAC_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  fpa_pkg::fpa_side_t         in_side,
    input  logic [NUM_W-1:0]           in_num,
    input  logic [fpa_pkg::WORD_W-1:0] in_den,
    output logic                       out_valid,
    output fpa_pkg::fpa_side_t         out_side,
    output logic [NUM_W-1:0]           out_quot,
    output logic [fpa_pkg::WORD_W-1:0] out_rem,
    output logic [fpa_pkg::WORD_W-1:0] out_den
);

    logic                       v   [NUM_W+1];
    fpa_pkg::fpa_side_t         sd  [NUM_W+1];
    logic [NUM_W-1:0]           nm  [NUM_W+1];
    logic [fpa_pkg::WORD_W-1:0] rm  [NUM_W+1];
    logic [fpa_pkg::WORD_W-1:0] dn  [NUM_W+1];

    assign v[0]  = in_valid;
    assign sd[0] = in_side;
    assign nm[0] = in_num;
    assign rm[0] = '0;
    assign dn[0] = in_den;

    for (genvar k = 0; k < NUM_W; k++)
    begin : g_step
        fpa_div_stage #(.NUM_W(NUM_W)) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (v[k]),
            .in_side   (sd[k]),
            .in_num    (nm[k]),
            .in_rem    (rm[k]),
            .in_den    (dn[k]),
            .out_valid (v[k+1]),
            .out_side  (sd[k+1]),
            .out_num   (nm[k+1]),
            .out_rem   (rm[k+1]),
            .out_den   (dn[k+1])
        );
    end

    assign out_valid = v[NUM_W];
    assign out_side  = sd[NUM_W];
    assign out_quot  = nm[NUM_W];
    assign out_rem   = rm[NUM_W];
    assign out_den   = dn[NUM_W];

endmodule

FILE: src/fixed_point_q24_8_alu.sv
// signed q24.8 fixed-point alu, top level
// depends on fpa_pkg and fpa_divider
//
// usage
//   req channel: req_valid with a packed request (req_type, operand_a,
//   operand_b); a request is taken at a clock edge with req_valid high and
//   req_stall low. rsp channel: rsp_valid with a packed response
//   (result_value, compare_true, status), taken when rsp_stall is low.
// pipeline
//   every request passes the same stages: an operand register, a stage for
//   multiply and the simple operations, one stage per quotient bit of the
//   32 + FRAC_BITS bit divider chain, and the rounding / output register.
//   all operations share that depth, so responses leave in request order.
//   one request per cycle is accepted while req_stall is low.
// stall
//   the whole pipeline advances together; while a response sits in the
//   output register and rsp_stall is high, every stage holds and req_stall
//   is raised. with the output register empty the pipeline never stalls.
// reset
//   rst_n clears all valid bits at once; payload registers are not reset.
module fixed_point_q24_8_alu #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  fpa_pkg::fpa_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output fpa_pkg::fpa_rsp_t rsp
);

    localparam int W     = fpa_pkg::WORD_W;
    localparam int NUM_W = W + FRAC_BITS;

    logic en;

    // operand register
    logic         s1_valid_reg;
    fpa_pkg::fpa_req_t s1_req_reg;

    // multiply / simple ops stage
    logic               s2_valid_reg;
    fpa_pkg::fpa_side_t s2_side_reg, s2_side_next;
    logic [NUM_W-1:0]   s2_num_reg, s2_num_next;
    logic [W-1:0]       s2_den_reg, s2_den_next;

    // divider outputs
    logic               dv_valid;
    fpa_pkg::fpa_side_t dv_side;
    logic [NUM_W-1:0]   dv_quot;
    logic [W-1:0]       dv_rem;
    logic [W-1:0]       dv_den;

    // output register
    logic              rsp_valid_reg;
    fpa_pkg::fpa_rsp_t rsp_reg, rsp_next;

    // advance whenever the output register can take a response
    assign en        = !rsp_valid_reg || !rsp_stall;
    assign req_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= req_valid;
            s2_valid_reg  <= s1_valid_reg;
            rsp_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_req_reg  <= req;
            s2_side_reg <= s2_side_next;
            s2_num_reg  <= s2_num_next;
            s2_den_reg  <= s2_den_next;
            rsp_reg     <= rsp_next;
        end
    end

    // stage two: magnitudes, product, and everything that needs no divide
    logic [W-1:0]     a, b, ma, mb;
    logic [W:0]       a_x, b_x;
    logic [W:0]       to_int_sum;
    logic [W:0]       bias;
    logic             from_ovf;
    fpa_pkg::fpa_sat_t sat;

    always_comb
    begin
        a    = s1_req_reg.operand_a;
        b    = s1_req_reg.operand_b;
        a_x  = {a[W-1], a};
        b_x  = {b[W-1], b};
        ma   = a[W-1] ? (~a + 1'b1) : a;
        mb   = b[W-1] ? (~b + 1'b1) : b;
        bias = {{(W+1-FRAC_BITS){1'b0}}, {FRAC_BITS{a[W-1]}}};
        to_int_sum = a_x + bias;
        // from_int overflows unless the top FRAC_BITS+1 bits agree
        from_ovf = !((&a[W-1:W-1-FRAC_BITS]) || !(|a[W-1:W-1-FRAC_BITS]));
        sat  = '0;

        s2_side_next      = '0;
        s2_side_next.op   = fpa_pkg::fpa_op_t'(s1_req_reg.req_type);
        s2_side_next.neg  = a[W-1] ^ b[W-1];
        s2_side_next.prod = ma * mb;
        s2_side_next.st   = fpa_pkg::ST_OK;
        s2_num_next       = {ma, {FRAC_BITS{1'b0}}};
        s2_den_next       = mb;

        unique case (s2_side_next.op)
            fpa_pkg::OP_ADD:
            begin
                sat = fpa_pkg::fpa_sat_sum(a_x + b_x);
            end
            fpa_pkg::OP_SUB:
            begin
                sat = fpa_pkg::fpa_sat_sum(a_x - b_x);
            end
            fpa_pkg::OP_INC:
            begin
                sat = fpa_pkg::fpa_sat_sum(a_x + 1'b1);
            end
            fpa_pkg::OP_DEC:
            begin
                sat = fpa_pkg::fpa_sat_sum(a_x - 1'b1);
            end
            fpa_pkg::OP_MIN:
            begin
                sat.value = ($signed(a) < $signed(b)) ? a : b;
            end
            fpa_pkg::OP_MAX:
            begin
                sat.value = ($signed(a) > $signed(b)) ? a : b;
            end
            fpa_pkg::OP_TO_INT:
            begin
                sat.value = W'($signed(to_int_sum) >>> FRAC_BITS);
            end
            fpa_pkg::OP_FROM_INT:
            begin
                sat.ovf   = from_ovf;
                sat.value = from_ovf ? (a[W-1] ? fpa_pkg::WORD_MIN : fpa_pkg::WORD_MAX)
                                     : (a << FRAC_BITS);
            end
            fpa_pkg::OP_GT: s2_side_next.cmp = $signed(a) >  $signed(b);
            fpa_pkg::OP_LT: s2_side_next.cmp = $signed(a) <  $signed(b);
            fpa_pkg::OP_GE: s2_side_next.cmp = $signed(a) >= $signed(b);
            fpa_pkg::OP_LE: s2_side_next.cmp = $signed(a) <= $signed(b);
            fpa_pkg::OP_EQ: s2_side_next.cmp = a == b;
            fpa_pkg::OP_NE: s2_side_next.cmp = a != b;
            fpa_pkg::OP_DIV:
            begin
                if (b == '0)
                begin
                    s2_side_next.st = fpa_pkg::ST_DIVZ;
                end
            end
            default:
            begin
                // multiply is finished after the divider chain
            end
        endcase

        s2_side_next.res = sat.value;
        if (sat.ovf)
        begin
            s2_side_next.st = fpa_pkg::ST_OVF;
        end
    end

    fpa_divider #(.NUM_W(NUM_W)) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s2_valid_reg),
        .in_side   (s2_side_reg),
        .in_num    (s2_num_reg),
        .in_den    (s2_den_reg),
        .out_valid (dv_valid),
        .out_side  (dv_side),
        .out_quot  (dv_quot),
        .out_rem   (dv_rem),
        .out_den   (dv_den)
    );

    // final stage: round half away from zero, apply sign, saturate
    logic [2*W:0]      mul_mag;
    logic [2*W:0]      div_mag;
    logic              round_up;
    fpa_pkg::fpa_sat_t fin;

    always_comb
    begin
        mul_mag  = ({1'b0, dv_side.prod} + ((2*W+1)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        round_up = {dv_rem, 1'b0} >= {1'b0, dv_den};
        div_mag  = (2*W+1)'(dv_quot) + (2*W+1)'(round_up);
        fin      = '0;

        rsp_next.result_value = dv_side.res;
        rsp_next.compare_true = dv_side.cmp;
        rsp_next.status       = dv_side.st;

        if (dv_side.op == fpa_pkg::OP_MUL)
        begin
            fin = fpa_pkg::fpa_sat_mag(mul_mag, dv_side.neg);
            rsp_next.result_value = fin.value;
            rsp_next.status       = fin.ovf ? fpa_pkg::ST_OVF : fpa_pkg::ST_OK;
        end
        else if (dv_side.op == fpa_pkg::OP_DIV && dv_side.st != fpa_pkg::ST_DIVZ)
        begin
            fin = fpa_pkg::fpa_sat_mag(div_mag, dv_side.neg);
            rsp_next.result_value = fin.value;
            rsp_next.status       = fin.ovf ? fpa_pkg::ST_OVF : fpa_pkg::ST_OK;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: src/fpa_checker.sv
// port-level checker for the q24.8 alu, bound to the top level
// depends on fpa_pkg and fixed_point_q24_8_alu_defines.svh
`include "fixed_point_q24_8_alu_defines.svh"

module fpa_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              req_stall,
    input logic              rsp_valid,
    input logic              rsp_stall,
    input fpa_pkg::fpa_rsp_t rsp
);

    logic blocked;
    logic cmp_hit;
    logic cmp_clean;
    logic divz_hit;
    logic divz_clean;

    assign blocked    = rsp_valid && rsp_stall;
    assign cmp_hit    = rsp_valid && rsp.compare_true;
    assign cmp_clean  = rsp.result_value == '0 && rsp.status == fpa_pkg::ST_OK;
    assign divz_hit   = rsp_valid && rsp.status == fpa_pkg::ST_DIVZ;
    assign divz_clean = rsp.result_value == '0 && !rsp.compare_true;

    // a stalled response stays put
    `FPA_ASSERT_NXT(a_rsp_hold, clk, rst_n, blocked, rsp_valid && $stable(rsp), "held rsp moved")

    // back pressure only comes from a blocked response
    `FPA_ASSERT_IMP(a_stall_src, clk, rst_n, req_stall, blocked, "stall without blocked response")

    // comparisons report only the flag
    `FPA_ASSERT_IMP(a_cmp_clean, clk, rst_n, cmp_hit, cmp_clean, "compare with value or status")

    // divide by zero returns zero
    `FPA_ASSERT_IMP(a_divz_zero, clk, rst_n, divz_hit, divz_clean, "bad divide by zero response")

endmodule

bind fixed_point_q24_8_alu fpa_checker u_fpa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

FILE: test/fixed_point_q24_8_alu_tb.sv
// testbench for the signed q24.8 fixed-point alu: directed and random requests
// depends on fpa_pkg and the fixed_point_q24_8_alu top level
module fixed_point_q24_8_alu_tb;

    localparam int FRAC    = 8;
    localparam int LATENCY = FRAC + 35;

    logic              clk;
    logic              rst_n;
    logic              req_valid;
    logic              req_stall;
    fpa_pkg::fpa_req_t req;
    logic              rsp_valid;
    logic              rsp_stall;
    fpa_pkg::fpa_rsp_t rsp;

    fixed_point_q24_8_alu #(.FRAC_BITS(FRAC)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // requests waiting to be driven, responses waiting to be seen
    fpa_pkg::fpa_req_t pending_reqs[$];
    fpa_pkg::fpa_rsp_t expected_rsps[$];
    int       mismatches;
    int       idle_pct;
    int       stall_pct;
    bit       stim_done;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // saturate a wide signed value to the word range
    function automatic logic [31:0] clamp_word(input longint v, inout logic [1:0] st);
        if (v > 64'sd2147483647)
        begin
            st = fpa_pkg::ST_OVF;
            return fpa_pkg::WORD_MAX;
        end
        if (v < -64'sd2147483648)
        begin
            st = fpa_pkg::ST_OVF;
            return fpa_pkg::WORD_MIN;
        end
        return v[31:0];
    endfunction

    // apply a sign to a rounded magnitude and saturate
    function automatic logic [31:0] signed_mag(input longint unsigned m, input bit neg,
                                               inout logic [1:0] st);
        if (neg)
        begin
            if (m > 64'h8000_0000)
            begin
                st = fpa_pkg::ST_OVF;
                return fpa_pkg::WORD_MIN;
            end
            return 32'(-m);
        end
        if (m > 64'h7FFF_FFFF)
        begin
            st = fpa_pkg::ST_OVF;
            return fpa_pkg::WORD_MAX;
        end
        return m[31:0];
    endfunction

    // expected response for one request
    function automatic fpa_pkg::fpa_rsp_t alu_result(input fpa_pkg::fpa_req_t r);
        fpa_pkg::fpa_rsp_t e;
        longint           a;
        longint           b;
        longint unsigned  ma;
        longint unsigned  mb;
        longint unsigned  q;
        bit               neg;
        a   = longint'(signed'(r.operand_a));
        b   = longint'(signed'(r.operand_b));
        ma  = a < 0 ? -a : a;
        mb  = b < 0 ? -b : b;
        neg = (a < 0) != (b < 0);
        e   = '0;
        case (fpa_pkg::fpa_op_t'(r.req_type))
            fpa_pkg::OP_ADD: e.result_value = clamp_word(a + b, e.status);
            fpa_pkg::OP_SUB: e.result_value = clamp_word(a - b, e.status);
            fpa_pkg::OP_MUL:
            begin
                // product fits in 63 bits, half lsb then shift
                q = (ma * mb + (64'd1 << (FRAC - 1))) >> FRAC;
                e.result_value = signed_mag(q, neg && q != 0, e.status);
            end
            fpa_pkg::OP_DIV:
            begin
                if (b == 0)
                    e.status = fpa_pkg::ST_DIVZ;
                else
                begin
                    q = (2 * (ma << FRAC) + mb) / (2 * mb);
                    e.result_value = signed_mag(q, neg && q != 0, e.status);
                end
            end
            fpa_pkg::OP_GT:  e.compare_true = a > b;
            fpa_pkg::OP_LT:  e.compare_true = a < b;
            fpa_pkg::OP_GE:  e.compare_true = a >= b;
            fpa_pkg::OP_LE:  e.compare_true = a <= b;
            fpa_pkg::OP_EQ:  e.compare_true = a == b;
            fpa_pkg::OP_NE:  e.compare_true = a != b;
            fpa_pkg::OP_INC: e.result_value = clamp_word(a + 1, e.status);
            fpa_pkg::OP_DEC: e.result_value = clamp_word(a - 1, e.status);
            fpa_pkg::OP_MIN: e.result_value = (a < b) ? a[31:0] : b[31:0];
            fpa_pkg::OP_MAX: e.result_value = (a > b) ? a[31:0] : b[31:0];
            // truncation toward zero
            fpa_pkg::OP_TO_INT: e.result_value = 32'(a / (64'sd1 <<< FRAC));
            default: e.result_value = clamp_word(a * (64'sd1 <<< FRAC), e.status);
        endcase
        return e;
    endfunction

    function automatic logic [31:0] rand_operand();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0:       v = fpa_pkg::WORD_MAX - $urandom_range(0, 3);
            1:       v = fpa_pkg::WORD_MIN + $urandom_range(0, 3);
            2:       v = $urandom_range(0, 7) - 4;
            3, 4:    v = {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
            5:       v = {{24{$urandom_range(0, 1) == 1}}, 8'($urandom)};
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic add_request(input fpa_pkg::fpa_op_t op, input logic [31:0] a,
                               input logic [31:0] b);
        fpa_pkg::fpa_req_t r;
        r.req_type  = op;
        r.operand_a = a;
        r.operand_b = b;
        pending_reqs.push_back(r);
    endtask

    // driver: a request holds its payload until taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
        end
        else
        begin
            if (req_valid && !req_stall)
                expected_rsps.push_back(alu_result(req));
            if (!req_valid || !req_stall)
            begin
                if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    req_valid <= 1'b1;
                    req       <= pending_reqs.pop_front();
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // monitor: compares each taken response with the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        fpa_pkg::fpa_rsp_t e;
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsps.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected response %h", rsp);
                end
                else
                begin
                    e = expected_rsps.pop_front();
                    if (rsp.result_value !== e.result_value
                        || rsp.compare_true !== e.compare_true
                        || rsp.status !== e.status)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected value %h cmp %b st %0d, got %h %b %0d",
                                     e.result_value, e.compare_true, e.status,
                                     rsp.result_value, rsp.compare_true, rsp.status);
                    end
                end
            end
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // stimulus: directed corners, then random phases with different idling
    initial
    begin
        int phase;
        int n;
        fpa_pkg::fpa_op_t op;
        mismatches = 0;
        idle_pct   = 0;
        stall_pct  = 0;
        stim_done  = 1'b0;
        rst_n      = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // extremes and special cases
        add_request(fpa_pkg::OP_ADD, fpa_pkg::WORD_MAX, 32'd1);
        add_request(fpa_pkg::OP_SUB, fpa_pkg::WORD_MIN, 32'd1);
        add_request(fpa_pkg::OP_MUL, fpa_pkg::WORD_MIN, fpa_pkg::WORD_MIN);
        add_request(fpa_pkg::OP_MUL, 32'h0000_0180, 32'hFFFF_FF80);
        add_request(fpa_pkg::OP_MUL, 32'd1, 32'h0000_0080);
        add_request(fpa_pkg::OP_MUL, 32'hFFFF_FFFF, 32'h0000_007F);
        add_request(fpa_pkg::OP_DIV, 32'h0000_0100, 32'd0);
        add_request(fpa_pkg::OP_DIV, fpa_pkg::WORD_MIN, 32'hFFFF_FFFF);
        add_request(fpa_pkg::OP_DIV, 32'd1, 32'hFFFF_FE00);
        add_request(fpa_pkg::OP_DIV, fpa_pkg::WORD_MIN, 32'h0000_0100);
        add_request(fpa_pkg::OP_GT, fpa_pkg::WORD_MAX, fpa_pkg::WORD_MIN);
        add_request(fpa_pkg::OP_LT, fpa_pkg::WORD_MIN, fpa_pkg::WORD_MAX);
        add_request(fpa_pkg::OP_GE, 32'd5, 32'd5);
        add_request(fpa_pkg::OP_LE, 32'd6, 32'd5);
        add_request(fpa_pkg::OP_EQ, fpa_pkg::WORD_MIN, fpa_pkg::WORD_MIN);
        add_request(fpa_pkg::OP_NE, 32'd0, 32'hFFFF_FFFF);
        add_request(fpa_pkg::OP_INC, fpa_pkg::WORD_MAX, fpa_pkg::WORD_MIN);
        add_request(fpa_pkg::OP_DEC, fpa_pkg::WORD_MIN, fpa_pkg::WORD_MAX);
        add_request(fpa_pkg::OP_MIN, fpa_pkg::WORD_MIN, fpa_pkg::WORD_MAX);
        add_request(fpa_pkg::OP_MAX, fpa_pkg::WORD_MIN, fpa_pkg::WORD_MAX);
        add_request(fpa_pkg::OP_TO_INT, 32'hFFFF_FE80, 32'd0);
        add_request(fpa_pkg::OP_TO_INT, fpa_pkg::WORD_MIN, fpa_pkg::WORD_MAX);
        add_request(fpa_pkg::OP_FROM_INT, 32'h0080_0000, 32'd0);
        add_request(fpa_pkg::OP_FROM_INT, 32'hFF7F_FFFF, 32'd0);
        add_request(fpa_pkg::OP_FROM_INT, 32'hFFFF_FFFF, fpa_pkg::WORD_MIN);

        // no idling, sender idle, receiver stall, both
        for (phase = 0; phase < 4; phase++)
        begin
            idle_pct  = (phase == 1) ? 65 : (phase == 3) ? 33 : 0;
            stall_pct = (phase == 2) ? 65 : (phase == 3) ? 33 : 0;
            for (n = 0; n < 450; n++)
            begin
                op = fpa_pkg::fpa_op_t'($urandom_range(0, 15));
                add_request(op, rand_operand(),
                            ($urandom_range(0, 19) == 0) ? 32'd0 : rand_operand());
            end
            wait (pending_reqs.size() == 0);
        end
        @(posedge clk);
        stim_done = 1'b1;
    end

    // end of run
    initial
    begin
        wait (stim_done);
        wait (expected_rsps.size() == 0 && !req_valid);
        repeat (2 * LATENCY) @(posedge clk);
        if (mismatches == 0 && expected_rsps.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule

FILE: files.f
+incdir+src
src/fpa_pkg.sv
src/fpa_div_stage.sv
src/fpa_divider.sv
src/fixed_point_q24_8_alu.sv
src/fpa_checker.sv
test/fixed_point_q24_8_alu_tb.sv
